// ===== sv/ofb_pkg.sv =====
// ----------------------------------------------------------------------------
// ofb_pkg
// Shared types and constants for the overwrite byte FIFO.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ofb_pkg;

   // default number of physical byte slots
   localparam int DEPTH_DEFAULT = 256;

   // capacity register value after reset
   localparam int CAP_RESET = 256;

   // field widths fixed by the interface
   localparam int DATA_W   = 8;
   localparam int OFFSET_W = 8;
   localparam int COUNT_W  = 9;
   localparam int CSR_W    = 9;

   // operation codes
   typedef enum logic [1:0] {
      KIND_PUT   = 2'd0,
      KIND_GET   = 2'd1,
      KIND_PEEK  = 2'd2,
      KIND_CLEAR = 2'd3
   } kind_type;

   // per-item result information that travels alongside the memory read
   typedef struct packed {
      logic               rd;     // a stored byte is read for this item
      logic [COUNT_W-1:0] fill;   // bytes held after the operation
   } meta_type;

endpackage

`default_nettype wire

// ===== sv/ofb_ram.sv =====
// ----------------------------------------------------------------------------
// ofb_ram
// Generic single-port RAM with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ofb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     en,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write or read one entry per cycle
   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== sv/ofb_ctrl.sv =====
// ----------------------------------------------------------------------------
// ofb_ctrl
// Pointer and fill-count unit: issues the memory access, if any, for each item and
// updates the ring state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ofb_ctrl
   import ofb_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     accept,
   input  wire logic [1:0]               kind,
   input  wire logic [DATA_W-1:0]        put_byte,
   input  wire logic [OFFSET_W-1:0]      peek_offset,
   input  wire logic                     csr_we,
   input  wire logic [CSR_W-1:0]         csr_wdata,
   output logic                          mem_en,
   output logic                          mem_we,
   output logic      [$clog2(DEPTH)-1:0] mem_addr,
   output logic      [DATA_W-1:0]        mem_wdata,
   output meta_type                      meta
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CAP_W = (PTR_W + 1 > CSR_W) ? PTR_W + 1 : CSR_W;
   localparam int CAP_INIT = (CAP_RESET > DEPTH) ? DEPTH : CAP_RESET;
   localparam logic [CAP_W-1:0] DEPTH_C = CAP_W'(DEPTH);
   localparam logic [CAP_W-1:0] ONE_C   = CAP_W'(1);

   logic [CAP_W-1:0]   cap_ff, cap_in;
   logic [PTR_W-1:0]   oldest_ff, oldest_in;
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [COUNT_W-1:0] held_ff, held_in;

   logic [CAP_W-1:0]   csr_ext;
   logic [CAP_W-1:0]   held_ext;
   logic               full;
   logic               peek_hit;
   logic [CAP_W:0]     peek_sum;
   logic [CAP_W:0]     peek_pos;
   logic [PTR_W-1:0]   oldest_next;
   logic [PTR_W-1:0]   wr_ptr_next;
   kind_type           op;

   // step a pointer by one, wrapping at the capacity in use
   function automatic logic [PTR_W-1:0] step_ptr(input logic [PTR_W-1:0] p,
                                                 input logic [CAP_W-1:0] cap);
      logic [CAP_W-1:0] inc;
      inc = CAP_W'(p) + ONE_C;
      step_ptr = (inc >= cap) ? '0 : inc[PTR_W-1:0];
   endfunction

   assign op          = kind_type'(kind);
   assign csr_ext     = CAP_W'(csr_wdata);
   assign held_ext    = CAP_W'(held_ff);
   assign full        = (held_ext >= cap_ff);
   assign peek_hit    = ({1'b0, peek_offset} < held_ff);
   assign peek_sum    = (CAP_W + 1)'(oldest_ff) + (CAP_W + 1)'(peek_offset);
   assign peek_pos    = (peek_sum >= {1'b0, cap_ff}) ? peek_sum - {1'b0, cap_ff}
                                                     : peek_sum;
   assign oldest_next = step_ptr(oldest_ff, cap_ff);
   assign wr_ptr_next = step_ptr(wr_ptr_ff, cap_ff);

   // decode the operation into a memory access and the next ring state
   always_comb begin
      cap_in    = cap_ff;
      oldest_in = oldest_ff;
      wr_ptr_in = wr_ptr_ff;
      held_in   = held_ff;
      mem_en    = 1'b0;
      mem_we    = 1'b0;
      mem_addr  = wr_ptr_ff;
      mem_wdata = put_byte;
      meta.rd   = 1'b0;

      if (csr_we) begin
         // clamp the capacity to one through DEPTH and empty the buffer
         if (csr_ext == '0) begin
            cap_in = ONE_C;
         end else if (csr_ext > DEPTH_C) begin
            cap_in = DEPTH_C;
         end else begin
            cap_in = csr_ext;
         end
         oldest_in = '0;
         wr_ptr_in = '0;
         held_in   = '0;
      end else if (accept) begin
         case (op)
            KIND_PUT: begin
               mem_en    = 1'b1;
               mem_we    = 1'b1;
               mem_addr  = wr_ptr_ff;
               wr_ptr_in = wr_ptr_next;
               if (full) begin
                  held_in   = cap_ff[COUNT_W-1:0];
                  oldest_in = oldest_next;
               end else begin
                  held_in = held_ff + COUNT_W'(1);
               end
            end
            KIND_GET: begin
               if (held_ff != '0) begin
                  mem_en    = 1'b1;
                  mem_addr  = oldest_ff;
                  meta.rd   = 1'b1;
                  oldest_in = oldest_next;
                  held_in   = held_ff - COUNT_W'(1);
               end
            end
            KIND_PEEK: begin
               if (peek_hit) begin
                  mem_en   = 1'b1;
                  mem_addr = peek_pos[PTR_W-1:0];
                  meta.rd  = 1'b1;
               end
            end
            KIND_CLEAR: begin
               oldest_in = '0;
               wr_ptr_in = '0;
               held_in   = '0;
            end
            default: begin
               held_in = held_ff;
            end
         endcase
      end
      meta.fill = held_in;
   end

   // hold the ring state
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff    <= CAP_W'(CAP_INIT);
         oldest_ff <= '0;
         wr_ptr_ff <= '0;
         held_ff   <= '0;
      end else begin
         cap_ff    <= cap_in;
         oldest_ff <= oldest_in;
         wr_ptr_ff <= wr_ptr_in;
         held_ff   <= held_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/overwrite_byte_fifo.sv =====
// ----------------------------------------------------------------------------
// overwrite_byte_fifo
// Byte ring buffer that drops its oldest byte when a put finds it full.
// ----------------------------------------------------------------------------
//   channel  direction  handshake            payload
//   req_     in         req_valid/req_stall  kind, put_byte, peek_offset
//   rsp_     out        rsp_valid/rsp_stall  read_byte, read_valid, fill_count
//   csr_     in         csr_we               capacity (wdata)
//
// One item per cycle unless a stall holds the flow; each result passes through
// the RAM read register, loaded at its transfer edge, and then the output register.
// The single RAM port carries at most one put write or one get/peek read per item.
// Synchronous reset empties the buffer and sets capacity to its reset value;
// the byte store itself needs no clearing.
// A stalled result holds the read stage, which then stalls the request side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module overwrite_byte_fifo
   import ofb_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [1:0]          req_kind,
   input  wire logic [DATA_W-1:0]   req_put_byte,
   input  wire logic [OFFSET_W-1:0] req_peek_offset,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic      [DATA_W-1:0]   rsp_read_byte,
   output logic                     rsp_read_valid,
   output logic      [COUNT_W-1:0]  rsp_fill_count,
   input  wire logic                csr_we,
   input  wire logic [CSR_W-1:0]    csr_wdata
);

   localparam int PTR_W = $clog2(DEPTH);

   logic               accept;
   logic               mem_en;
   logic               mem_we;
   logic [PTR_W-1:0]   mem_addr;
   logic [DATA_W-1:0]  mem_wdata;
   logic [DATA_W-1:0]  mem_rdata;
   meta_type           meta;

   logic               s1_valid_ff, s1_valid_in;
   meta_type           s1_meta_ff;
   logic               out_valid_ff, out_valid_in;
   logic [DATA_W-1:0]  out_byte_ff;
   logic               out_rd_ff;
   logic [COUNT_W-1:0] out_fill_ff;
   logic               out_free;
   logic               s1_move;

   // advance the read stage whenever the output register can take it
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign s1_move   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   ofb_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .kind        (req_kind),
      .put_byte    (req_put_byte),
      .peek_offset (req_peek_offset),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .mem_en      (mem_en),
      .mem_we      (mem_we),
      .mem_addr    (mem_addr),
      .mem_wdata   (mem_wdata),
      .meta        (meta)
   );

   ofb_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .en    (mem_en),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   always_comb begin
      s1_valid_in  = accept || (s1_valid_ff && !out_free);
      out_valid_in = s1_move || (out_valid_ff && rsp_stall);
   end

   // read stage and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (accept) begin
         s1_meta_ff <= meta;
      end
      if (s1_move) begin
         out_byte_ff <= s1_meta_ff.rd ? mem_rdata : '0;
         out_rd_ff   <= s1_meta_ff.rd;
         out_fill_ff <= s1_meta_ff.fill;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_read_byte  = out_byte_ff;
   assign rsp_read_valid = out_rd_ff;
   assign rsp_fill_count = out_fill_ff;

endmodule

`default_nettype wire
